// ===== rtl/dll_pkg.sv =====
`default_nettype none

package dll_pkg;

   // Node numbering: nodes 0 .. NODE_COUNT-1, the value NODE_COUNT means none
   localparam int NODE_COUNT = 64;
   localparam int NODE_W     = $clog2(NODE_COUNT);
   localparam int LINK_W     = $clog2(NODE_COUNT + 1);

   localparam logic [LINK_W-1:0] NIL = LINK_W'(NODE_COUNT);

   typedef enum logic [3:0] {
      OP_INS_AFTER    = 4'd0,
      OP_INS_BEFORE   = 4'd1,
      OP_INS_FRONT    = 4'd2,
      OP_INS_BACK     = 4'd3,
      OP_REMOVE       = 4'd4,
      OP_REMOVE_FRONT = 4'd5,
      OP_FIRST        = 4'd6,
      OP_LAST         = 4'd7,
      OP_PREV         = 4'd8,
      OP_NEXT         = 4'd9
   } op_type;

   typedef enum logic [1:0] {
      STAT_DONE    = 2'd0,
      STAT_IGNORED = 2'd1,
      STAT_EMPTY   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_STEP0 = 2'd1,
      ST_STEP1 = 2'd2
   } state_type;

   // One access bundle for a link memory: one read and one write port
   typedef struct packed {
      logic              re;
      logic [NODE_W-1:0] raddr;
      logic              we;
      logic [NODE_W-1:0] waddr;
      logic [LINK_W-1:0] wdata;
   } ram_req_type;

   function automatic logic link_ok(input logic [LINK_W-1:0] v);
      return v < NIL;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/dll_link_ram.sv =====
`default_nettype none

module dll_link_ram (
   input  wire logic                        clock,
   input  wire dll_pkg::ram_req_type        req,
   output logic [dll_pkg::LINK_W-1:0]       rd_data
);
   import dll_pkg::*;

   logic [LINK_W-1:0] link_mem [NODE_COUNT];
   logic [LINK_W-1:0] rd_data_ff;

   // Entries hold no reset value: the user must write each before it is read; the RAM does not enforce it
   always_ff @(posedge clock) begin
      if (req.we) begin
         link_mem[req.waddr] <= req.wdata;
      end
      if (req.re) begin
         rd_data_ff <= link_mem[req.raddr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/dll_ctrl.sv =====
`default_nettype none

module dll_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [3:0]                  req_opcode,
   input  wire logic [dll_pkg::NODE_W-1:0]  req_new_node,
   input  wire logic [dll_pkg::LINK_W-1:0]  req_ref_node,
   input  wire logic [dll_pkg::LINK_W-1:0]  next_rd,
   input  wire logic [dll_pkg::LINK_W-1:0]  prev_rd,
   output dll_pkg::ram_req_type             next_req,
   output dll_pkg::ram_req_type             prev_req,
   output logic                             rsp_valid,
   output logic [dll_pkg::LINK_W-1:0]       rsp_result_node,
   output logic [dll_pkg::LINK_W-1:0]       rsp_list_size,
   output logic [1:0]                       rsp_status
);
   import dll_pkg::*;

   state_type         state_ff, state_in;
   op_type            op_ff;
   logic [NODE_W-1:0] nn_ff;
   logic [LINK_W-1:0] rn_ff;
   logic [LINK_W-1:0] head_ff, head_in;
   logic [LINK_W-1:0] tail_ff, tail_in;
   logic [LINK_W-1:0] count_ff, count_in;
   logic              rsp_valid_ff;
   logic [LINK_W-1:0] rsp_node_ff, rsp_node_in;
   logic [LINK_W-1:0] rsp_size_ff;
   status_type        rsp_stat_ff, rsp_stat_in;

   logic              accept;
   logic              last_step;
   logic              grow, shrink;
   logic [LINK_W-1:0] nn_link;
   logic              ref_ok, x_ok, p_ok, head_ok, tail_ok, cnt_zero, empty;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign last_step = (state_ff == ST_STEP1);
   assign nn_link   = LINK_W'(nn_ff);
   assign ref_ok    = link_ok(rn_ff);
   assign x_ok      = link_ok(next_rd);
   assign p_ok      = link_ok(prev_rd);
   assign head_ok   = link_ok(head_ff);
   assign tail_ok   = link_ok(tail_ff);
   assign cnt_zero  = (count_ff == '0);
   assign empty     = cnt_zero || !head_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= NIL;
         tail_ff      <= NIL;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= last_step;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= op_type'(req_opcode);
         nn_ff <= req_new_node;
         rn_ff <= req_ref_node;
      end
      if (last_step) begin
         rsp_node_ff <= rsp_node_in;
         rsp_size_ff <= count_in;
         rsp_stat_ff <= rsp_stat_in;
      end
   end

   // Sequencer: read links on accept, then two write steps
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (start) state_in = ST_STEP0;
         ST_STEP0: state_in = ST_STEP1;
         ST_STEP1: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Read addresses come from the request word, or from the head for a front removal;
   // link writes are kept in the order the list rules apply them
   always_comb begin
      next_req.re    = 1'b0;
      next_req.raddr = req_new_node;
      prev_req.re    = 1'b0;
      prev_req.raddr = req_new_node;
      next_req.we    = 1'b0;
      next_req.waddr = nn_ff;
      next_req.wdata = NIL;
      prev_req.we    = 1'b0;
      prev_req.waddr = nn_ff;
      prev_req.wdata = NIL;
      if (accept) begin
         case (op_type'(req_opcode))
            OP_INS_AFTER: begin
               next_req.re    = 1'b1;
               next_req.raddr = req_ref_node[NODE_W-1:0];
            end
            OP_INS_BEFORE: begin
               prev_req.re    = 1'b1;
               prev_req.raddr = req_ref_node[NODE_W-1:0];
            end
            OP_REMOVE: begin
               next_req.re = 1'b1;
               prev_req.re = 1'b1;
            end
            OP_REMOVE_FRONT: begin
               next_req.re    = 1'b1;
               next_req.raddr = head_ff[NODE_W-1:0];
            end
            OP_PREV:  prev_req.re = 1'b1;
            OP_NEXT:  next_req.re = 1'b1;
            default:  ;
         endcase
      end
      if (state_ff == ST_STEP0) begin
         case (op_ff)
            OP_INS_AFTER: if (ref_ok) begin
               next_req.we    = 1'b1;
               next_req.waddr = rn_ff[NODE_W-1:0];
               next_req.wdata = nn_link;
               prev_req.we    = x_ok;
               prev_req.waddr = next_rd[NODE_W-1:0];
               prev_req.wdata = nn_link;
            end
            OP_INS_BEFORE: if (ref_ok) begin
               prev_req.we    = 1'b1;
               prev_req.waddr = rn_ff[NODE_W-1:0];
               prev_req.wdata = nn_link;
               next_req.we    = p_ok;
               next_req.waddr = prev_rd[NODE_W-1:0];
               next_req.wdata = nn_link;
            end
            OP_INS_FRONT: begin
               next_req.we    = 1'b1;
               next_req.wdata = head_ff;
               prev_req.we    = 1'b1;
            end
            OP_INS_BACK: begin
               prev_req.we    = 1'b1;
               prev_req.wdata = tail_ff;
               next_req.we    = 1'b1;
            end
            OP_REMOVE: begin
               next_req.we    = p_ok;
               next_req.waddr = prev_rd[NODE_W-1:0];
               next_req.wdata = next_rd;
               prev_req.we    = x_ok;
               prev_req.waddr = next_rd[NODE_W-1:0];
               prev_req.wdata = prev_rd;
            end
            OP_REMOVE_FRONT: begin
               prev_req.we    = !empty && x_ok;
               prev_req.waddr = next_rd[NODE_W-1:0];
            end
            default: ;
         endcase
      end else if (last_step) begin
         case (op_ff)
            OP_INS_AFTER: if (ref_ok) begin
               next_req.we    = 1'b1;
               next_req.wdata = next_rd;
               prev_req.we    = 1'b1;
               prev_req.wdata = rn_ff;
            end
            OP_INS_BEFORE: if (ref_ok) begin
               prev_req.we    = 1'b1;
               prev_req.wdata = prev_rd;
               next_req.we    = 1'b1;
               next_req.wdata = rn_ff;
            end
            OP_INS_FRONT: begin
               prev_req.we    = !cnt_zero && head_ok;
               prev_req.waddr = head_ff[NODE_W-1:0];
               prev_req.wdata = nn_link;
            end
            OP_INS_BACK: begin
               next_req.we    = !cnt_zero && tail_ok;
               next_req.waddr = tail_ff[NODE_W-1:0];
               next_req.wdata = nn_link;
            end
            OP_REMOVE: begin
               next_req.we = 1'b1;
               prev_req.we = 1'b1;
            end
            OP_REMOVE_FRONT: begin
               next_req.we    = !empty;
               next_req.waddr = head_ff[NODE_W-1:0];
               prev_req.we    = !empty;
               prev_req.waddr = head_ff[NODE_W-1:0];
            end
            default: ;
         endcase
      end
   end

   // Head, tail and size commit on the last step, with the result word
   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      grow        = 1'b0;
      shrink      = 1'b0;
      rsp_node_in = NIL;
      rsp_stat_in = STAT_DONE;
      if (last_step) begin
         case (op_ff)
            OP_INS_AFTER: begin
               if (!ref_ok) begin
                  rsp_stat_in = STAT_IGNORED;
               end else begin
                  if (!x_ok) tail_in = nn_link;
                  grow = 1'b1;
               end
            end
            OP_INS_BEFORE: begin
               if (!ref_ok) begin
                  rsp_stat_in = STAT_IGNORED;
               end else begin
                  if (!p_ok) head_in = nn_link;
                  grow = 1'b1;
               end
            end
            OP_INS_FRONT: begin
               head_in = nn_link;
               if (cnt_zero) tail_in = nn_link;
               grow = 1'b1;
            end
            OP_INS_BACK: begin
               tail_in = nn_link;
               if (cnt_zero) head_in = nn_link;
               grow = 1'b1;
            end
            OP_REMOVE: begin
               if (head_ff == nn_link) head_in = next_rd;
               if (tail_ff == nn_link) tail_in = prev_rd;
               shrink      = 1'b1;
               rsp_node_in = nn_link;
            end
            OP_REMOVE_FRONT: begin
               if (empty) begin
                  rsp_stat_in = STAT_EMPTY;
               end else begin
                  head_in = next_rd;
                  if (!x_ok) tail_in = NIL;
                  shrink      = 1'b1;
                  rsp_node_in = head_ff;
               end
            end
            OP_FIRST: rsp_node_in = head_ff;
            OP_LAST:  rsp_node_in = tail_ff;
            OP_PREV:  rsp_node_in = prev_rd;
            OP_NEXT:  rsp_node_in = next_rd;
            default:  ;
         endcase
      end
   end

   // Saturating size counter
   always_comb begin
      count_in = count_ff;
      if (grow && (count_ff < NIL)) begin
         count_in = count_ff + LINK_W'(1);
      end else if (shrink && !cnt_zero) begin
         count_in = count_ff - LINK_W'(1);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_node = rsp_node_ff;
   assign rsp_list_size   = rsp_size_ff;
   assign rsp_status      = rsp_stat_ff;

`ifndef SYNTHESIS
   a_accept_to_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##3 rsp_valid_ff)
      else $error("accepted word gave no response three cycles later");

   a_rsp_only_after_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff) == ST_STEP1)
      else $error("response strobe without a finished operation");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !(next_req.we || prev_req.we))
      else $error("link write while idle");

   a_read_on_accept: assert property (@(posedge clock) disable iff (reset)
      (next_req.re || prev_req.re) |-> accept)
      else $error("link read outside an accept");

   a_size_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= NIL)
      else $error("list size above node count");
`endif

endmodule

`default_nettype wire

// ===== rtl/doubly_linked_list_manager.sv =====
`default_nettype none

// Doubly linked list manager: head, tail, size in flops, next/prev links in two RAMs.
// rsp_valid and the response word are registered together as the last write step ends;
// each operation is one link read, then two write steps; a new one is taken only when idle.
// busy is high for the two write steps; the receiver cannot stall responses.
// Synchronous active-high reset empties the list; link RAMs are not cleared.
module doubly_linked_list_manager (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [3:0]                  req_opcode,
   input  wire logic [dll_pkg::NODE_W-1:0]  req_new_node,
   input  wire logic [dll_pkg::LINK_W-1:0]  req_ref_node,
   output logic                             rsp_valid,
   output logic [dll_pkg::LINK_W-1:0]       rsp_result_node,
   output logic [dll_pkg::LINK_W-1:0]       rsp_list_size,
   output logic [1:0]                       rsp_status
);
   import dll_pkg::*;

   // Access bundles for the two link memories
   ram_req_type       next_req;
   ram_req_type       prev_req;
   logic [LINK_W-1:0] next_rd;
   logic [LINK_W-1:0] prev_rd;

   // Sequencer: decode the word, read the neighbor links during the accept
   // cycle, then use two write steps to write up to two entries in each RAM and
   // commit head, tail and size with the response on the last step.
   dll_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_new_node    (req_new_node),
      .req_ref_node    (req_ref_node),
      .next_rd         (next_rd),
      .prev_rd         (prev_rd),
      .next_req        (next_req),
      .prev_req        (prev_req),
      .rsp_valid       (rsp_valid),
      .rsp_result_node (rsp_result_node),
      .rsp_list_size   (rsp_list_size),
      .rsp_status      (rsp_status)
   );

   // Forward links: entry n holds the node after n, or none
   dll_link_ram u_next_ram (
      .clock   (clock),
      .req     (next_req),
      .rd_data (next_rd)
   );

   // Backward links: entry n holds the node before n, or none
   dll_link_ram u_prev_ram (
      .clock   (clock),
      .req     (prev_req),
      .rd_data (prev_rd)
   );

endmodule

`default_nettype wire

// ===== bench/dll_list_checker.sv =====
module dll_list_checker (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic                        busy,
   input  wire logic [3:0]                  req_opcode,
   input  wire logic [dll_pkg::NODE_W-1:0]  req_new_node,
   input  wire logic [dll_pkg::LINK_W-1:0]  req_ref_node,
   input  wire logic                        rsp_valid,
   input  wire logic [dll_pkg::LINK_W-1:0]  rsp_result_node,
   input  wire logic [dll_pkg::LINK_W-1:0]  rsp_list_size,
   input  wire logic [1:0]                  rsp_status,
   output int                               fail_count,
   output int                               open_count
);
   import dll_pkg::*;

   typedef struct packed {
      logic [LINK_W-1:0] node;
      logic [LINK_W-1:0] size;
      status_type        status;
   } reply_type;

   logic [LINK_W-1:0] head_ptr, tail_ptr, list_len;
   logic [LINK_W-1:0] next_link [NODE_COUNT];
   logic [LINK_W-1:0] prev_link [NODE_COUNT];
   reply_type         expected_replies [$];
   int                fail_total = 0;

   // Apply one operation to the shadow list and return the reply it must give.
   // A 6-bit node number is always in range, so only the reference needs a test.
   function automatic reply_type apply_list_op(input logic [3:0]        opc,
                                               input logic [NODE_W-1:0] nn,
                                               input logic [LINK_W-1:0] rn);
      reply_type         r;
      logic [LINK_W-1:0] node, nbr_p, nbr_n, old_head;
      node     = LINK_W'(nn);
      r.node   = NIL;
      r.status = STAT_DONE;
      case (opc)
         OP_INS_AFTER, OP_INS_BEFORE: begin
            if (rn >= NIL) begin
               r.status = STAT_IGNORED;
            end else if (opc == OP_INS_AFTER) begin
               nbr_n = next_link[rn[NODE_W-1:0]];
               if (nbr_n < NIL) prev_link[nbr_n[NODE_W-1:0]] = node;
               else tail_ptr = node;
               next_link[rn[NODE_W-1:0]] = node;
               next_link[nn] = nbr_n;
               prev_link[nn] = rn;
               if (list_len < NIL) list_len++;
            end else begin
               nbr_p = prev_link[rn[NODE_W-1:0]];
               if (nbr_p < NIL) next_link[nbr_p[NODE_W-1:0]] = node;
               else head_ptr = node;
               prev_link[rn[NODE_W-1:0]] = node;
               prev_link[nn] = nbr_p;
               next_link[nn] = rn;
               if (list_len < NIL) list_len++;
            end
         end
         OP_INS_FRONT: begin
            next_link[nn] = head_ptr;
            prev_link[nn] = NIL;
            if (list_len == 0) begin
               head_ptr = node;
               tail_ptr = node;
            end else begin
               if (head_ptr < NIL) prev_link[head_ptr[NODE_W-1:0]] = node;
               head_ptr = node;
            end
            if (list_len < NIL) list_len++;
         end
         OP_INS_BACK: begin
            prev_link[nn] = tail_ptr;
            next_link[nn] = NIL;
            if (list_len == 0) begin
               head_ptr = node;
               tail_ptr = node;
            end else begin
               if (tail_ptr < NIL) next_link[tail_ptr[NODE_W-1:0]] = node;
               tail_ptr = node;
            end
            if (list_len < NIL) list_len++;
         end
         OP_REMOVE: begin
            nbr_p = prev_link[nn];
            nbr_n = next_link[nn];
            if (head_ptr == node) head_ptr = nbr_n;
            if (tail_ptr == node) tail_ptr = nbr_p;
            if (nbr_p < NIL) next_link[nbr_p[NODE_W-1:0]] = nbr_n;
            if (nbr_n < NIL) prev_link[nbr_n[NODE_W-1:0]] = nbr_p;
            prev_link[nn] = NIL;
            next_link[nn] = NIL;
            if (list_len != 0) list_len--;
            r.node = node;
         end
         OP_REMOVE_FRONT: begin
            if (list_len == 0 || head_ptr >= NIL) begin
               r.status = STAT_EMPTY;
            end else begin
               old_head = head_ptr;
               nbr_n    = next_link[old_head[NODE_W-1:0]];
               head_ptr = nbr_n;
               if (nbr_n >= NIL) tail_ptr = NIL;
               else prev_link[nbr_n[NODE_W-1:0]] = NIL;
               prev_link[old_head[NODE_W-1:0]] = NIL;
               next_link[old_head[NODE_W-1:0]] = NIL;
               if (list_len != 0) list_len--;
               r.node = old_head;
            end
         end
         OP_FIRST: r.node = head_ptr;
         OP_LAST:  r.node = tail_ptr;
         OP_PREV:  r.node = prev_link[nn];
         OP_NEXT:  r.node = next_link[nn];
         default: ;
      endcase
      r.size = list_len;
      return r;
   endfunction

   // Check the reply first: a reply and a new request can share one edge.
   always @(posedge clock) begin
      reply_type want;
      if (reset) begin
         head_ptr = NIL;
         tail_ptr = NIL;
         list_len = '0;
         for (int i = 0; i < NODE_COUNT; i++) begin
            next_link[i] = NIL;
            prev_link[i] = NIL;
         end
         expected_replies.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_replies.size() == 0) begin
               $display("%0t: reply with none expected: got node %0d size %0d status %0d",
                        $time, rsp_result_node, rsp_list_size, rsp_status);
               fail_total++;
            end else begin
               want = expected_replies.pop_front();
               if (rsp_result_node !== want.node || rsp_list_size !== want.size ||
                   rsp_status !== want.status) begin
                  $display("%0t: reply mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                           $time, want.node, want.size, want.status,
                           rsp_result_node, rsp_list_size, rsp_status);
                  fail_total++;
               end
            end
         end
         if (start && !busy)
            expected_replies.push_back(apply_list_op(req_opcode, req_new_node, req_ref_node));
      end
      fail_count <= fail_total;
      open_count <= expected_replies.size();
   end

endmodule

// ===== bench/tb.sv =====
module tb;
   import dll_pkg::*;

   // Opcodes the block does not define; they must answer none with the current size
   localparam logic [3:0]        OP_SPARE_LO  = 4'd10;
   localparam logic [3:0]        OP_SPARE_HI  = 4'd15;
   localparam logic [LINK_W-1:0] REF_TOP      = '1;

   // Node selection modes for pick_node
   localparam int PICK_FREE    = 0;
   localparam int PICK_WRITTEN = 1;
   localparam int PICK_STALE   = 2;

   localparam int RANDOM_WORDS = 1800;
   localparam int ABUSE_WORDS  = 40;
   localparam int QUIET_FROM   = 700;
   localparam int QUIET_LEN    = 300;
   localparam int CYCLE_LIMIT  = 200000;

   logic              clock;
   logic              reset        = 1'b1;
   logic              start        = 1'b0;
   logic              busy;
   logic [3:0]        req_opcode   = '0;
   logic [NODE_W-1:0] req_new_node = '0;
   logic [LINK_W-1:0] req_ref_node = '0;
   logic              rsp_valid;
   logic [LINK_W-1:0] rsp_result_node;
   logic [LINK_W-1:0] rsp_list_size;
   logic [1:0]        rsp_status;

   int fail_count;
   int open_count;
   int cycle_count = 0;

   // Stimulus-side bookkeeping: which nodes sit in the list (in order) and which
   // nodes ever had their links written. Prev, next and remove words name written nodes only.
   bit                in_list [NODE_COUNT];
   bit                written [NODE_COUNT];
   logic [NODE_W-1:0] order [$];
   bit                quiet     = 1'b0;
   bit                shadow_on = 1'b1;

   doubly_linked_list_manager i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_new_node    (req_new_node),
      .req_ref_node    (req_ref_node),
      .rsp_valid       (rsp_valid),
      .rsp_result_node (rsp_result_node),
      .rsp_list_size   (rsp_list_size),
      .rsp_status      (rsp_status)
   );

   dll_list_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_new_node    (req_new_node),
      .req_ref_node    (req_ref_node),
      .rsp_valid       (rsp_valid),
      .rsp_result_node (rsp_result_node),
      .rsp_list_size   (rsp_list_size),
      .rsp_status      (rsp_status),
      .fail_count      (fail_count),
      .open_count      (open_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: end a hung run with a failure
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic logic [NODE_W-1:0] rand_node();
      return NODE_W'($urandom_range(0, NODE_COUNT - 1));
   endfunction

   // Any reference value, in range or not
   function automatic logic [LINK_W-1:0] rand_ref();
      return LINK_W'($urandom());
   endfunction

   // A reference that means none: NIL or anything above it
   function automatic logic [LINK_W-1:0] rand_none();
      return LINK_W'($urandom_range(NODE_COUNT, REF_TOP));
   endfunction

   // Scan from a random start for a node of the requested kind; -1 if none exists
   function automatic int pick_node(input int mode);
      int k;
      int first;
      first = $urandom_range(0, NODE_COUNT - 1);
      for (int i = 0; i < NODE_COUNT; i++) begin
         k = (first + i) % NODE_COUNT;
         case (mode)
            PICK_FREE:    if (!in_list[k]) return k;
            PICK_WRITTEN: if (written[k]) return k;
            default:      if (written[k] && !in_list[k]) return k;
         endcase
      end
      return -1;
   endfunction

   // Send one request word and return once it is taken. Insert a random idle gap
   // first unless in the quiet stretch; keep start high between back-to-back words.
   task automatic issue_op(input logic [3:0]        opc,
                           input logic [NODE_W-1:0] nn,
                           input logic [LINK_W-1:0] rn);
      int gap;
      int pos;
      gap = 0;
      pos = 0;
      if (!quiet && $urandom_range(0, 99) < 35) gap = $urandom_range(1, 3);
      if (gap > 0) begin
         // the block stays busy through both write steps of the previous word
         start <= 1'b0;
         repeat (gap + 2) @(posedge clock);
      end
      start        <= 1'b1;
      req_opcode   <= opc;
      req_new_node <= nn;
      req_ref_node <= rn;
      // busy read here is the value the edge saw
      @(posedge clock);
      while (busy) @(posedge clock);

      // Mark links of a freshly placed node as written
      if (opc == OP_INS_FRONT || opc == OP_INS_BACK ||
          ((opc == OP_INS_AFTER || opc == OP_INS_BEFORE) && rn < NIL))
         written[nn] = 1'b1;

      // Follow the list order while all traffic is well formed
      if (shadow_on) begin
         case (opc)
            OP_INS_AFTER, OP_INS_BEFORE: begin
               if (rn < NIL) begin
                  foreach (order[i]) if (order[i] == rn[NODE_W-1:0]) pos = i;
                  order.insert((opc == OP_INS_AFTER) ? pos + 1 : pos, nn);
                  in_list[nn] = 1'b1;
               end
            end
            OP_INS_FRONT: begin
               order.push_front(nn);
               in_list[nn] = 1'b1;
            end
            OP_INS_BACK: begin
               order.push_back(nn);
               in_list[nn] = 1'b1;
            end
            OP_REMOVE: begin
               if (in_list[nn]) begin
                  foreach (order[i]) if (order[i] == nn) pos = i;
                  order.delete(pos);
                  in_list[nn] = 1'b0;
               end
            end
            OP_REMOVE_FRONT: begin
               if (order.size() != 0) begin
                  in_list[order[0]] = 1'b0;
                  void'(order.pop_front());
               end
            end
            default: ;
         endcase
      end
   endtask

   // Insert a node that is not in the list, at a random place
   task automatic insert_free();
      logic [NODE_W-1:0] nn;
      logic [NODE_W-1:0] anchor;
      int                kind;
      nn   = NODE_W'(pick_node(PICK_FREE));
      kind = (order.size() == 0) ? $urandom_range(2, 3) : $urandom_range(0, 3);
      anchor = (order.size() == 0) ? '0 : order[$urandom_range(0, order.size() - 1)];
      case (kind)
         0:       issue_op(OP_INS_AFTER, nn, LINK_W'(anchor));
         1:       issue_op(OP_INS_BEFORE, nn, LINK_W'(anchor));
         2:       issue_op(OP_INS_FRONT, nn, rand_ref());
         default: issue_op(OP_INS_BACK, nn, rand_ref());
      endcase
   endtask

   // One well-formed random word; grow_bias favors inserts, else removes
   task automatic random_list_op(input bit grow_bias);
      int         roll;
      int         pick;
      logic [3:0] spare_op;
      roll = $urandom_range(0, 99);
      if (roll < (grow_bias ? 60 : 15)) begin
         if (order.size() < NODE_COUNT) begin
            insert_free();
            return;
         end
      end else if (roll < 75) begin
         if (order.size() == 0)
            issue_op(OP_REMOVE_FRONT, rand_node(), rand_ref());
         else if ($urandom_range(0, 1))
            issue_op(OP_REMOVE, order[$urandom_range(0, order.size() - 1)], rand_ref());
         else
            issue_op(OP_REMOVE_FRONT, rand_node(), rand_ref());
         return;
      end

      // Queries and words the block must ignore
      roll = $urandom_range(0, 9);
      case (roll)
         0: issue_op(OP_FIRST, rand_node(), rand_ref());
         1: issue_op(OP_LAST, rand_node(), rand_ref());
         2, 3, 4, 5: begin
            pick = pick_node(PICK_WRITTEN);
            if (pick < 0) issue_op(OP_FIRST, rand_node(), rand_ref());
            else issue_op((roll < 4) ? OP_PREV : OP_NEXT, NODE_W'(pick), rand_ref());
         end
         6: issue_op($urandom_range(0, 1) ? OP_INS_AFTER : OP_INS_BEFORE, rand_node(),
                     rand_none());
         7: begin
            spare_op = 4'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
            issue_op(spare_op, rand_node(), rand_ref());
         end
         8: issue_op((order.size() == 0) ? OP_REMOVE_FRONT : OP_LAST, rand_node(), rand_ref());
         default: begin
            // neighbors of a node that left the list read back as none
            pick = pick_node(PICK_STALE);
            if (pick < 0) pick = pick_node(PICK_WRITTEN);
            if (pick < 0) issue_op(OP_LAST, rand_node(), rand_ref());
            else issue_op($urandom_range(0, 1) ? OP_PREV : OP_NEXT, NODE_W'(pick), rand_ref());
         end
      endcase
   endtask

   initial begin
      int         burst_left;
      bit         grow_bias;
      int         pick;
      logic [3:0] opc;

      // Hold reset at the start, then release it for good
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty-list answers, ignored references, spare opcodes
      issue_op(OP_FIRST, 6'd0, NIL);
      issue_op(OP_LAST, 6'd63, REF_TOP);
      issue_op(OP_REMOVE_FRONT, 6'd0, '0);
      issue_op(OP_INS_AFTER, 6'd3, NIL);
      issue_op(OP_INS_BEFORE, 6'd63, REF_TOP);
      issue_op(OP_SPARE_LO, 6'd63, REF_TOP);
      issue_op(OP_SPARE_HI, 6'd0, '0);
      // Build 9 0 5 7 63 11 through every insert form, at both ends and the middle
      issue_op(OP_INS_FRONT, 6'd0, REF_TOP);
      issue_op(OP_INS_BACK, 6'd63, '0);
      issue_op(OP_INS_AFTER, 6'd5, 7'd0);
      issue_op(OP_INS_BEFORE, 6'd7, 7'd63);
      issue_op(OP_INS_BEFORE, 6'd9, 7'd0);
      issue_op(OP_INS_AFTER, 6'd11, 7'd63);
      issue_op(OP_FIRST, 6'd0, '0);
      issue_op(OP_LAST, 6'd0, '0);
      issue_op(OP_PREV, 6'd0, '0);
      issue_op(OP_NEXT, 6'd0, '0);
      issue_op(OP_PREV, 6'd9, '0);
      issue_op(OP_NEXT, 6'd11, '0);
      // Remove from the middle, the head and the tail, then empty from the front
      issue_op(OP_REMOVE, 6'd5, '0);
      issue_op(OP_REMOVE, 6'd9, '0);
      issue_op(OP_REMOVE, 6'd11, '0);
      repeat (4) issue_op(OP_REMOVE_FRONT, 6'd63, REF_TOP);
      issue_op(OP_NEXT, 6'd5, '0);

      // Random well-formed traffic in alternating grow and shrink bursts; the grow
      // bursts are long enough to fill the list now and then
      grow_bias  = 1'b1;
      burst_left = $urandom_range(150, 220);
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         quiet = (n >= QUIET_FROM && n < QUIET_FROM + QUIET_LEN);
         if (burst_left == 0) begin
            grow_bias  = !grow_bias;
            burst_left = $urandom_range(60, 220);
         end
         burst_left--;
         random_list_op(grow_bias);
      end
      quiet = 1'b0;

      // Drain the list, then remove a node that is no longer in it: size stays at zero
      while (order.size() != 0) begin
         if ($urandom_range(0, 1))
            issue_op(OP_REMOVE_FRONT, rand_node(), rand_ref());
         else
            issue_op(OP_REMOVE, order[$urandom_range(0, order.size() - 1)], rand_ref());
      end
      pick = pick_node(PICK_STALE);
      if (pick >= 0) issue_op(OP_REMOVE, NODE_W'(pick), rand_ref());

      // Fill every node, then insert a member again: size stays at the maximum
      while (order.size() < NODE_COUNT) insert_free();
      shadow_on = 1'b0;
      issue_op(OP_INS_FRONT, order[$urandom_range(0, NODE_COUNT - 1)], rand_ref());

      // Free-form words with caller rules broken; every node is written by now
      for (int n = 0; n < ABUSE_WORDS; n++) begin
         opc  = 4'($urandom());
         pick = pick_node(PICK_WRITTEN);
         case (opc)
            OP_INS_AFTER, OP_INS_BEFORE:
               issue_op(opc, rand_node(), $urandom_range(0, 1) ? LINK_W'(pick) : rand_none());
            OP_REMOVE, OP_PREV, OP_NEXT:
               issue_op(opc, NODE_W'(pick), rand_ref());
            default:
               issue_op(opc, rand_node(), rand_ref());
         endcase
      end
      start <= 1'b0;

      // Wait for the last replies, then let the clock run on before the verdict
      do @(posedge clock); while (open_count != 0);
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/dll_pkg.sv
rtl/dll_link_ram.sv
rtl/dll_ctrl.sv
rtl/doubly_linked_list_manager.sv
bench/dll_list_checker.sv
bench/tb.sv
